FILE: rtl/core/dltq_pkg.sv
// Shared types, codes and control/status bundles of the delta-list timer queue.
`timescale 1ns / 1ps

package dltq_pkg;

    // Fixed widths of the channel payloads
    localparam int OP_W     = 2;
    localparam int REQ_ID_W = 16;
    localparam int REQ_DLY_W = 16;
    localparam int STATUS_W = 3;
    localparam int RSP_ID_W = 16;
    localparam int RSP_CNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_MISSING   = 3'd2,
        ST_EXPIRED   = 3'd3,
        ST_NO_EXPIRY = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_SHUP,
        S_PLACE,
        S_FIND,
        S_SHDN,
        S_TAKEN,
        S_TCHK,
        S_EMIT
    } t_state;

    // Address source for the storage read port
    typedef enum logic [2:0] {
        RD_ZERO,
        RD_POS_NEXT,
        RD_TOP,
        RD_SHUP_NEXT,
        RD_SHDN_NEXT
    } t_rd_sel;

    // Kind of result being staged
    typedef enum logic [2:0] {
        RK_FULL,
        RK_DONE,
        RK_TAKEN,
        RK_MISS,
        RK_NONE,
        RK_EXPIRE
    } t_res_kind;

    typedef struct packed {
        logic      in_ready;
        t_rd_sel   rd_sel;
        logic      walk_step;
        logic      pos_step;
        logic      shup_start;
        logic      shup_step;
        logic      place;
        logic      take_start;
        logic      shdn_step;
        logic      count_dec;
        logic      head_dec;
        logic      res_set;
        t_res_kind res_kind;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        t_op  in_op;
        t_op  op;
        logic full;
        logic count_zero;
        logic at_end;
        logic walk_more;
        logic hit;
        logic head_big;
        logic shup_last;
        logic shdn_none;
        logic shdn_last;
        logic res_last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/core/dltq_req_if.sv
// Request channel: operation, entry id and delay with valid/ready.
`timescale 1ns / 1ps

interface dltq_req_if;
    import dltq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [REQ_ID_W-1:0]  entry_id;
    logic [REQ_DLY_W-1:0] delay;

    modport source (output valid, output operation, output entry_id, output delay,
                    input ready);
    modport sink   (input valid, input operation, input entry_id, input delay,
                    output ready);
endinterface

FILE: rtl/core/dltq_rsp_if.sv
// Response channel: status, id, entry count and last marker with valid/ready.
`timescale 1ns / 1ps

interface dltq_rsp_if;
    import dltq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [RSP_ID_W-1:0]  result_id;
    logic [RSP_CNT_W-1:0] entry_count;
    logic                 last;

    modport source (output valid, output status, output result_id, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input result_id, input entry_count,
                    input last, output ready);
endinterface

FILE: rtl/core/dltq_ctrl.sv
// Sequencing state machine of the delta-list timer queue.
`timescale 1ns / 1ps

module dltq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dltq_pkg::t_sts i_sts,
    output dltq_pkg::t_cmd o_cmd
);
    import dltq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    if (i_sts.in_op == OP_INSERT) begin
                        n_state = i_sts.full ? S_EMIT : S_WALK;
                    end else begin
                        n_state = S_FIND;
                    end
                end
            end
            S_WALK: begin
                if (i_sts.at_end) begin
                    n_state = S_PLACE;
                end else if (!i_sts.walk_more) begin
                    n_state = S_SHUP;
                end
            end
            S_SHUP: begin
                if (i_sts.shup_last) begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: n_state = S_EMIT;
            S_FIND: begin
                if (i_sts.op == OP_TICK) begin
                    if (i_sts.count_zero || i_sts.head_big) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = i_sts.shdn_none ? S_TAKEN : S_SHDN;
                    end
                end else if (i_sts.at_end) begin
                    n_state = S_EMIT;
                end else if (i_sts.hit) begin
                    n_state = i_sts.shdn_none ? S_TAKEN : S_SHDN;
                end
            end
            S_SHDN: begin
                if (i_sts.shdn_last) begin
                    n_state = S_TAKEN;
                end
            end
            S_TAKEN: n_state = (i_sts.op == OP_TICK) ? S_TCHK : S_EMIT;
            S_TCHK:  n_state = S_EMIT;
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.res_last ? S_IDLE : S_FIND;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_ZERO;
        o_cmd.res_kind = RK_DONE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid && i_sts.in_op == OP_INSERT && i_sts.full) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RK_FULL;
                end
            end
            S_WALK: begin
                if (!i_sts.at_end) begin
                    if (i_sts.walk_more) begin
                        o_cmd.walk_step = 1'b1;
                        o_cmd.rd_sel    = RD_POS_NEXT;
                    end else begin
                        o_cmd.shup_start = 1'b1;
                        o_cmd.rd_sel     = RD_TOP;
                    end
                end
            end
            S_SHUP: begin
                o_cmd.shup_step = 1'b1;
                o_cmd.rd_sel    = RD_SHUP_NEXT;
            end
            S_PLACE: begin
                o_cmd.place    = 1'b1;
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = RK_DONE;
            end
            S_FIND: begin
                o_cmd.rd_sel = RD_POS_NEXT;
                if (i_sts.op == OP_TICK) begin
                    if (i_sts.count_zero) begin
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = RK_NONE;
                    end else if (i_sts.head_big) begin
                        o_cmd.head_dec = 1'b1;
                        o_cmd.res_set  = 1'b1;
                        o_cmd.res_kind = RK_NONE;
                    end else begin
                        o_cmd.take_start = 1'b1;
                    end
                end else if (i_sts.at_end) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RK_MISS;
                end else if (i_sts.hit) begin
                    o_cmd.take_start = 1'b1;
                end else begin
                    o_cmd.pos_step = 1'b1;
                end
            end
            S_SHDN: begin
                o_cmd.shdn_step = 1'b1;
                o_cmd.rd_sel    = RD_SHDN_NEXT;
            end
            S_TAKEN: begin
                o_cmd.count_dec = 1'b1;
                if (i_sts.op != OP_TICK) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_kind = RK_TAKEN;
                end
            end
            S_TCHK: begin
                o_cmd.res_set  = 1'b1;
                o_cmd.res_kind = RK_EXPIRE;
            end
            S_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
                o_cmd.rd_sel = RD_ZERO;
            end
        endcase
    end

endmodule

FILE: rtl/core/dltq_dp.sv
// Datapath: entry storage, walk registers, result staging and output register.
`timescale 1ns / 1ps

module dltq_dp #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dltq_req_if.sink       i_req,
    dltq_rsp_if.source     o_rsp,
    input  dltq_pkg::t_cmd i_cmd,
    output dltq_pkg::t_sts o_sts
);
    import dltq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ID_BITS + TIME_BITS;

    // Entry storage: id in the upper bits, delta in the lower bits
    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;

    logic [ID_BITS-1:0]   rd_id;
    logic [TIME_BITS-1:0] rd_delta;

    // Working registers
    t_op                  r_op;
    logic [ID_BITS-1:0]   r_id;
    logic [TIME_BITS-1:0] r_rem;
    logic [CW-1:0]        r_pos;
    logic [CW-1:0]        r_idx;
    logic [CW-1:0]        r_count;
    logic [ID_BITS-1:0]   r_got;
    logic [TIME_BITS-1:0] r_carry;

    // Staged result and output register
    t_status              r_res_status;
    logic [ID_BITS-1:0]   r_res_id;
    logic                 r_res_last;
    logic                 r_out_valid;
    t_status              r_out_status;
    logic [RSP_ID_W-1:0]  r_out_id;
    logic [RSP_CNT_W-1:0] r_out_count;
    logic                 r_out_last;

    logic [CW-1:0] pos_inc;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_m2;
    logic [CW-1:0] idx_p2;
    logic          in_beat;
    logic          out_free;

    assign rd_id    = r_rd[WW-1:TIME_BITS];
    assign rd_delta = r_rd[TIME_BITS-1:0];
    assign pos_inc  = r_pos + CW'(1);
    assign cnt_dec  = r_count - CW'(1);
    assign idx_m1   = r_idx - CW'(1);
    assign idx_m2   = r_idx - CW'(2);
    assign idx_p2   = r_idx + CW'(2);
    assign in_beat  = i_req.valid && i_cmd.in_ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // Read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS_NEXT:  rd_addr = pos_inc[AW-1:0];
            RD_TOP:       rd_addr = cnt_dec[AW-1:0];
            RD_SHUP_NEXT: rd_addr = idx_m2[AW-1:0];
            RD_SHDN_NEXT: rd_addr = idx_p2[AW-1:0];
            default:      rd_addr = '0;
        endcase
    end

    // Write port select: at most one write command per cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx[AW-1:0];
        wr_data = r_rd;
        if (i_cmd.shup_step) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[AW-1:0];
            wr_data = {rd_id, (idx_m1 == r_pos) ? rd_delta - r_rem : rd_delta};
        end else if (i_cmd.place) begin
            wr_en   = 1'b1;
            wr_addr = r_pos[AW-1:0];
            wr_data = {r_id, r_rem};
        end else if (i_cmd.shdn_step) begin
            wr_en   = 1'b1;
            wr_addr = r_idx[AW-1:0];
            wr_data = {rd_id, (r_idx == r_pos) ? rd_delta + r_carry : rd_delta};
        end else if (i_cmd.head_dec) begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {rd_id, rd_delta - TIME_BITS'(1)};
        end
    end

    // Storage array, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // Operation registers and walk pointers
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_op  <= t_op'(i_req.operation);
            r_id  <= ID_BITS'(i_req.entry_id);
            r_rem <= TIME_BITS'(i_req.delay);
            r_pos <= '0;
        end else if (i_cmd.walk_step) begin
            r_rem <= r_rem - rd_delta;
            r_pos <= pos_inc;
        end else if (i_cmd.pos_step) begin
            r_pos <= pos_inc;
        end

        if (i_cmd.shup_start) begin
            r_idx <= r_count;
        end else if (i_cmd.shup_step) begin
            r_idx <= idx_m1;
        end else if (i_cmd.take_start) begin
            r_idx <= r_pos;
        end else if (i_cmd.shdn_step) begin
            r_idx <= r_idx + CW'(1);
        end

        // A released head passes on no wait; a removed entry passes on its delta
        if (i_cmd.take_start) begin
            r_got   <= rd_id;
            r_carry <= (r_op == OP_TICK) ? '0 : rd_delta;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.place) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= cnt_dec;
        end
    end

    // Result staging
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            case (i_cmd.res_kind)
                RK_FULL: begin
                    r_res_status <= ST_FULL;
                    r_res_id     <= '0;
                    r_res_last   <= 1'b1;
                end
                RK_TAKEN: begin
                    r_res_status <= ST_DONE;
                    r_res_id     <= r_got;
                    r_res_last   <= 1'b1;
                end
                RK_MISS: begin
                    r_res_status <= ST_MISSING;
                    r_res_id     <= '0;
                    r_res_last   <= 1'b1;
                end
                RK_NONE: begin
                    r_res_status <= ST_NO_EXPIRY;
                    r_res_id     <= '0;
                    r_res_last   <= 1'b1;
                end
                RK_EXPIRE: begin
                    r_res_status <= ST_EXPIRED;
                    r_res_id     <= r_got;
                    r_res_last   <= (r_count == '0) || (rd_delta != '0);
                end
                default: begin
                    r_res_status <= ST_DONE;
                    r_res_id     <= '0;
                    r_res_last   <= 1'b1;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_id     <= RSP_ID_W'(r_res_id);
            r_out_count  <= RSP_CNT_W'(r_count);
            r_out_last   <= r_res_last;
        end
    end

    assign i_req.ready       = i_cmd.in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.result_id   = r_out_id;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.last        = r_out_last;

    // Status to the controller
    always_comb begin
        o_sts.in_valid   = i_req.valid;
        o_sts.in_op      = t_op'(i_req.operation);
        o_sts.op         = r_op;
        o_sts.full       = (r_count >= CW'(DEPTH));
        o_sts.count_zero = (r_count == '0);
        o_sts.at_end     = (r_pos >= r_count);
        o_sts.walk_more  = (r_rem > rd_delta);
        o_sts.hit        = (r_op != OP_REMOVE) || (rd_id == r_id);
        o_sts.head_big   = (rd_delta > TIME_BITS'(1));
        o_sts.shup_last  = (idx_m1 == r_pos);
        o_sts.shdn_none  = (pos_inc == r_count);
        o_sts.shdn_last  = (idx_p2 == r_count);
        o_sts.res_last   = r_res_last;
        o_sts.out_free   = out_free;
    end

endmodule

FILE: rtl/core/delta_list_timer_queue.sv
// Delta-list timer queue top level: controller plus datapath.
// Per beat: an insert walks one entry a cycle, then shifts up; a full insert is rejected;
// remove and pop search, then shift the later entries down and unlink the entry found.
// A tick releases the expired heads one after another, or else reports that none expired.
// Throughput: one request at a time; the next beat is taken the cycle after the last
// result enters the output register, which waits while a held result is not taken.
// Reset: synchronous; clears the entry count, state and output valid.
`timescale 1ns / 1ps

module delta_list_timer_queue #(
    parameter int DEPTH     = 16,
    parameter int ID_BITS   = 16,
    parameter int TIME_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dltq_req_if.sink   i_req,
    dltq_rsp_if.source o_rsp
);
    import dltq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    dltq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Storage and arithmetic
    dltq_dp #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

FILE: sim/tb_delta_list_timer_queue.sv
// Self-checking testbench for the delta-list timer queue, with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_delta_list_timer_queue;
    import dltq_pkg::*;

    localparam int DEPTH         = 16;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int CALM_ITEMS    = 60;
    localparam int SETTLE_CYCLES = 40;

    // Operation mixes for the random episodes
    localparam int MIX_FILL     = 0;
    localparam int MIX_BALANCED = 1;
    localparam int MIX_DRAIN    = 2;

    // Predicts the queue contents and the results of every accepted request beat
    class timer_queue_scoreboard;
        typedef struct packed {
            t_status     status;
            logic [15:0] id;
            logic [4:0]  count;
            logic        last;
        } t_expiry_result;

        logic [15:0]    wait_ids[$];
        logic [15:0]    wait_deltas[$];
        t_expiry_result expected_results[$];
        int             mismatches;
        int             results_checked;
        int             op_seen[4];
        int             expirations;
        int             full_rejects;
        int             missing_hits;
        int             widest_release;

        function new();
            mismatches      = 0;
            results_checked = 0;
            expirations     = 0;
            full_rejects    = 0;
            missing_hits    = 0;
            widest_release  = 0;
            foreach (op_seen[k]) op_seen[k] = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push_result(t_status st, logic [15:0] id, logic last);
            t_expiry_result r;
            r.status = st;
            r.id     = id;
            r.count  = 5'(wait_ids.size());
            r.last   = last;
            expected_results.push_back(r);
        endfunction

        // Unlink one entry, handing its delta on to its successor
        function logic [15:0] take_entry(int pos);
            logic [15:0] id;
            id = wait_ids[pos];
            if (pos + 1 < wait_ids.size())
                wait_deltas[pos + 1] = wait_deltas[pos + 1] + wait_deltas[pos];
            wait_ids.delete(pos);
            wait_deltas.delete(pos);
            return id;
        endfunction

        function void note_request(t_op op, logic [15:0] id, logic [15:0] dly);
            int          pos;
            int          released;
            logic [15:0] remaining;
            logic [15:0] got;
            logic        fin;
            op_seen[op]++;
            case (op)
                OP_INSERT: begin
                    if (wait_ids.size() >= DEPTH) begin
                        full_rejects++;
                        push_result(ST_FULL, 16'h0, 1'b1);
                    end else begin
                        pos       = 0;
                        remaining = dly;
                        while (pos < wait_ids.size() && remaining > wait_deltas[pos]) begin
                            remaining -= wait_deltas[pos];
                            pos++;
                        end
                        // ties land in front of the existing entry
                        if (pos < wait_ids.size())
                            wait_deltas[pos] = wait_deltas[pos] - remaining;
                        wait_ids.insert(pos, id);
                        wait_deltas.insert(pos, remaining);
                        push_result(ST_DONE, 16'h0, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    pos = 0;
                    while (pos < wait_ids.size() && wait_ids[pos] != id) pos++;
                    if (pos < wait_ids.size()) begin
                        got = take_entry(pos);
                        push_result(ST_DONE, got, 1'b1);
                    end else begin
                        missing_hits++;
                        push_result(ST_MISSING, 16'h0, 1'b1);
                    end
                end
                OP_POP: begin
                    if (wait_ids.size() == 0) begin
                        missing_hits++;
                        push_result(ST_MISSING, 16'h0, 1'b1);
                    end else begin
                        got = take_entry(0);
                        push_result(ST_DONE, got, 1'b1);
                    end
                end
                default: begin
                    released = 0;
                    if (wait_ids.size() > 0 && wait_deltas[0] != 16'h0)
                        wait_deltas[0] = wait_deltas[0] - 16'h1;
                    while (wait_ids.size() > 0 && wait_deltas[0] == 16'h0) begin
                        got = take_entry(0);
                        fin = (wait_ids.size() == 0) || (wait_deltas[0] != 16'h0);
                        push_result(ST_EXPIRED, got, fin);
                        released++;
                    end
                    if (released == 0)
                        push_result(ST_NO_EXPIRY, 16'h0, 1'b1);
                    expirations += released;
                    if (released > widest_release) widest_release = released;
                end
            endcase
        endfunction

        function void check_result(logic [2:0] st, logic [15:0] id, logic [4:0] count,
                                   logic last);
            t_expiry_result want;
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat status=%0d id=%h count=%0d last=%b",
                         $time, st, id, count, last);
                return;
            end
            want = expected_results.pop_front();
            if (st !== want.status) begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $time, want.status, st);
            end
            if (id !== want.id) begin
                mismatches++;
                $display("%0t: result_id expected %h actual %h", $time, want.id, id);
            end
            if (count !== want.count) begin
                mismatches++;
                $display("%0t: entry_count expected %0d actual %0d", $time, want.count, count);
            end
            if (last !== want.last) begin
                mismatches++;
                $display("%0t: last expected %b actual %b", $time, want.last, last);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic idle_on;
    int   stall_left;
    int   quiet_cycles;

    timer_queue_scoreboard sb;

    dltq_req_if req_bus();
    dltq_rsp_if rsp_bus();

    delta_list_timer_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Response back-pressure: random stall bursts while idling is enabled
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
        end else if (idle_on && $urandom_range(0, 6) == 0) begin
            stall_left    = $urandom_range(1, 11) - 1;
            rsp_bus.ready = 1'b0;
        end else begin
            rsp_bus.ready = 1'b1;
        end
    end

    // Beat monitor on both channels, plus the cycle count for the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_bus.valid && req_bus.ready)
                sb.note_request(t_op'(req_bus.operation), req_bus.entry_id, req_bus.delay);
            if (rsp_bus.valid && rsp_bus.ready)
                sb.check_result(rsp_bus.status, rsp_bus.result_id, rsp_bus.entry_count,
                                rsp_bus.last);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < WATCHDOG_MAX) @(posedge i_clk);
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 WATCHDOG_MAX, sb.pending());
        $display("FAIL");
        $finish;
    end

    // Present one request beat and hold it until accepted; returns on a falling edge
    task automatic send_request(t_op op, logic [15:0] id, logic [15:0] dly);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap           = $urandom_range(1, 11);
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid     = 1'b1;
        req_bus.operation = op;
        req_bus.entry_id  = id;
        req_bus.delay     = dly;
        do @(posedge i_clk); while (!req_bus.ready);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every predicted result has been seen
    task automatic wait_all_results();
        req_bus.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_op pick_op(int mix);
        int roll;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return roll < 70 ? OP_INSERT : roll < 80 ? OP_REMOVE :
                              roll < 88 ? OP_POP : OP_TICK;
            MIX_DRAIN: return roll < 10 ? OP_INSERT : roll < 30 ? OP_REMOVE :
                              roll < 50 ? OP_POP : OP_TICK;
            default:   return roll < 40 ? OP_INSERT : roll < 60 ? OP_REMOVE :
                              roll < 75 ? OP_POP : OP_TICK;
        endcase
    endfunction

    // Mostly short waits so ticks release entries; now and then long or extreme ones
    function automatic logic [15:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 16'($urandom_range(0, 6));
        if (roll < 85) return 16'($urandom_range(0, 300));
        if (roll < 95) return 16'($urandom);
        return roll[0] ? 16'hFFFF : 16'h0000;
    endfunction

    // Narrow ids give duplicates; removes mostly aim at entries actually waiting
    function automatic logic [15:0] pick_id(t_op op);
        if (op == OP_REMOVE && sb.wait_ids.size() != 0 && $urandom_range(0, 9) < 7)
            return sb.wait_ids[$urandom_range(0, sb.wait_ids.size() - 1)];
        if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    task automatic run_episode(int n_items, int mix);
        t_op op;
        repeat (n_items) begin
            op = pick_op(mix);
            send_request(op, pick_id(op), pick_delay());
        end
    endtask

    initial begin
        int done_items;
        int len;
        i_rst_n           = 1'b0;
        idle_on           = 1'b1;
        stall_left        = 0;
        quiet_cycles      = 0;
        req_bus.valid     = 1'b0;
        req_bus.operation = OP_INSERT;
        req_bus.entry_id  = 16'h0;
        req_bus.delay     = 16'h0;
        rsp_bus.ready     = 1'b0;
        sb                = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty queue: tick, pop and remove all have nothing to work on
        send_request(OP_TICK, 16'hFFFF, 16'hFFFF);
        send_request(OP_POP, 16'h0000, 16'h0000);
        send_request(OP_REMOVE, 16'h0001, 16'h8000);
        // Longest wait, then a zero wait that the next tick releases at once
        send_request(OP_INSERT, 16'hFFFF, 16'hFFFF);
        send_request(OP_INSERT, 16'h0000, 16'h0000);
        send_request(OP_TICK, 16'h0000, 16'h0000);
        // Ties go first; a duplicate id further back
        send_request(OP_INSERT, 16'h0005, 16'd10);
        send_request(OP_INSERT, 16'h0006, 16'd10);
        send_request(OP_INSERT, 16'h0007, 16'd3);
        send_request(OP_INSERT, 16'h0005, 16'd20);
        // Duplicate id: the one nearest the head goes; then an absent id
        send_request(OP_REMOVE, 16'h0005, 16'h0);
        send_request(OP_REMOVE, 16'h1234, 16'h0);
        send_request(OP_POP, 16'h0, 16'h0);
        // Three entries expiring on the same tick
        send_request(OP_INSERT, 16'hAAAA, 16'd1);
        send_request(OP_INSERT, 16'h5555, 16'd1);
        send_request(OP_INSERT, 16'h00FF, 16'd1);
        send_request(OP_TICK, 16'h0, 16'h0);
        // Nonzero head: nothing expires
        send_request(OP_TICK, 16'h0, 16'h0);
        wait_all_results();

        // Empty it, fill it to the brim, reject one more, then expire all in one tick
        while (sb.wait_ids.size() != 0) send_request(OP_POP, 16'($urandom), 16'($urandom));
        repeat (DEPTH) send_request(OP_INSERT, 16'($urandom), 16'd1);
        send_request(OP_INSERT, 16'($urandom), 16'($urandom));
        send_request(OP_TICK, 16'($urandom), 16'($urandom));
        wait_all_results();

        // Random episodes with varying mixes and idling
        done_items = 0;
        while (done_items < RANDOM_ITEMS - CALM_ITEMS) begin
            len     = $urandom_range(10, 40);
            idle_on = ($urandom_range(0, 2) != 0);
            run_episode(len, $urandom_range(MIX_FILL, MIX_DRAIN));
            done_items += len;
            if ($urandom_range(0, 3) == 0) wait_all_results();
        end

        // Closing stretch at full rate on both sides
        idle_on = 1'b0;
        run_episode(CALM_ITEMS, MIX_BALANCED);
        req_bus.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Requests: %0d insert, %0d remove, %0d pop, %0d tick; %0d result beats checked",
                 sb.op_seen[OP_INSERT], sb.op_seen[OP_REMOVE], sb.op_seen[OP_POP],
                 sb.op_seen[OP_TICK], sb.results_checked);
        $display("Expired %0d (up to %0d on one tick), %0d full rejects, %0d misses, %0d errors",
                 sb.expirations, sb.widest_release, sb.full_rejects, sb.missing_hits,
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
